// ===== hdl/utf8_to_utf16_utf32_transcoder_assert.svh =====
// ----------------------------------------------------------------------------
// utf8 transcoder assertion macros
// immediate-cycle and next-cycle implication checks, reset-qualified
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_UTF32_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_UTF32_TRANSCODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define U2U_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2u assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2u assertion failed: next-cycle check");

`endif

// ===== hdl/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg
// shared types, constants and encode helpers for the utf8 transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2u_pkg;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam logic [15:0] SURR_HI_OFS = 16'hD7C0;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;  // upper bits of 0xDC00

  typedef enum logic {
    FMT_UTF16 = 1'b0,
    FMT_UTF32 = 1'b1
  } out_fmt_t;

  typedef enum logic [1:0] {
    IDX_B0 = 2'd0,
    IDX_B1 = 2'd1,
    IDX_B2 = 2'd2,
    IDX_B3 = 2'd3
  } byte_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_input;
    logic       stream_done;
  } out_item_t;

  // one decoded unit of work: up to four output bytes, low byte first
  typedef struct packed {
    logic [31:0] data;
    byte_idx_t   last_idx;
    logic        bad;
    logic        eos;
  } job_t;

  typedef struct packed {
    logic [1:0] bytes_left;
    logic       dropping;
  } front_stat_t;

  function automatic job_t err_job(input logic eos);
    job_t j;
    j.data     = 32'd0;
    j.last_idx = IDX_B0;
    j.bad      = 1'b1;
    j.eos      = eos;
    return j;
  endfunction

  function automatic job_t encode_cp(input logic [20:0] cp, input out_fmt_t fmt,
                                     input logic eos);
    job_t        j;
    logic [15:0] hi;
    logic [15:0] lo;
    hi     = {5'd0, cp[20:10]} + SURR_HI_OFS;
    lo     = {SURR_LO_TAG, cp[9:0]};
    j.bad  = 1'b0;
    j.eos  = eos;
    if (fmt == FMT_UTF32) begin
      j.data     = {11'd0, cp};
      j.last_idx = IDX_B3;
    end else if (cp[20:16] == 5'd0) begin
      j.data     = {16'd0, cp[15:0]};
      j.last_idx = IDX_B1;
    end else begin
      j.data     = {lo, hi};
      j.last_idx = IDX_B3;
    end
    return j;
  endfunction

endpackage

// ===== hdl/utf8_to_utf16_utf32_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_transcoder
// Converts a UTF-8 byte stream into UTF-16LE or UTF-32LE bytes, one output
// byte per transaction. A byte is taken in any cycle where the job queue has
// room, so input flows back to back; the output side then drains at one byte
// per cycle while pop is held, which sets the sustained rate: a completed
// code point gives 2 bytes in UTF-16 (4 for a surrogate pair) and 4 in UTF-32,
// lead and middle bytes of a sequence give none, and an error gives one. The
// first byte of a result goes through the job queue and the output register.
// Malformed or truncated input gives one error transaction (out_byte 0,
// bad_input 1) and the rest of the stream up to its end mark is discarded.
// The output format register should only be written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_to_utf16_utf32_transcoder_assert.svh"

module utf8_to_utf16_utf32_transcoder (
  input  logic               clk,
  input  logic               rst_n,
  // input byte queue
  input  logic               push,
  output logic               full,
  input  u2u_pkg::in_item_t  in_item,
  // output byte queue
  output logic               empty,
  input  logic               pop,
  output u2u_pkg::out_item_t out_item,
  // format register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import u2u_pkg::*;

  out_fmt_t    out_fmt_r, out_fmt_nxt;
  logic        in_accept;
  logic        front_job_valid;
  job_t        front_job;
  front_stat_t front_stat;
  logic        fifo_full;
  logic        fifo_valid;
  job_t        fifo_job;
  logic        back_done;

  // format register, always ready to take a write
  assign cfg_ready   = 1'b1;
  assign out_fmt_nxt = (cfg_valid && cfg_ready) ? out_fmt_t'(cfg_data) : out_fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_fmt_r <= FMT_UTF16;
    end else begin
      out_fmt_r <= out_fmt_nxt;
    end
  end

  // input is back-pressured only by the job queue
  assign full      = fifo_full;
  assign in_accept = push && !fifo_full;

  // front: decode and classify each byte
  u2u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_item   (in_item),
    .fmt       (out_fmt_r),
    .job_valid (front_job_valid),
    .job       (front_job),
    .stat      (front_stat)
  );

  // queue of finished code points and error marks
  u2u_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_job_valid),
    .wr_job   (front_job),
    .full     (fifo_full),
    .rd_en    (back_done),
    .rd_job   (fifo_job),
    .rd_valid (fifo_valid)
  );

  // back: one output byte per transaction through a registered stage
  u2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (fifo_valid),
    .job       (fifo_job),
    .job_done  (back_done),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  // error transactions always close their run and carry a zero byte
  `U2U_ASSERT_NOW(a_err_closes_run, clk, rst_n, !empty && out_item.bad_input, out_item.last_of_run && (out_item.out_byte == 8'd0))

  // end of stream only marks the last byte of a run
  `U2U_ASSERT_NOW(a_done_is_last, clk, rst_n, !empty && out_item.stream_done, out_item.last_of_run)

  // decoder never raises a job while the queue is full
  `U2U_ASSERT_NOW(a_no_job_when_full, clk, rst_n, front_job_valid, !fifo_full)

  // an end-of-stream byte leaves the decoder fully cleared
  `U2U_ASSERT_NEXT(a_eos_clears, clk, rst_n, in_accept && in_item.end_of_stream, (front_stat.bytes_left == 2'd0) && !front_stat.dropping)

endmodule

// ===== hdl/u2u_front.sv =====
// ----------------------------------------------------------------------------
// u2u_front
// utf8 sequence decoder: classifies bytes, builds code points, raises jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  u2u_pkg::in_item_t  in_item,
  input  u2u_pkg::out_fmt_t  fmt,
  output logic               job_valid,
  output u2u_pkg::job_t      job,
  output u2u_pkg::front_stat_t stat
);
  import u2u_pkg::*;

  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        dropping_r, dropping_nxt;

  logic [7:0]  b;
  logic        eos;
  logic [20:0] acc_shift;
  logic [1:0]  bl_dec;
  logic        err;

  assign b         = in_item.in_byte;
  assign eos       = in_item.end_of_stream;
  assign acc_shift = {acc_r[14:0], b[5:0]};
  assign bl_dec    = bytes_left_r - 2'd1;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    dropping_nxt   = dropping_r;
    job_valid      = 1'b0;
    job            = err_job(eos);
    err            = 1'b0;
    if (accept && !dropping_r) begin
      if (bytes_left_r == 2'd0) begin
        if (!b[7]) begin
          job_valid = 1'b1;
          job       = encode_cp({13'd0, b}, fmt, eos);
          acc_nxt   = 21'd0;
        end else if (b[7:5] == 3'b110) begin
          acc_nxt        = {16'd0, b[4:0]};
          bytes_left_nxt = 2'd1;
          err            = eos;
        end else if (b[7:4] == 4'b1110) begin
          acc_nxt        = {17'd0, b[3:0]};
          bytes_left_nxt = 2'd2;
          err            = eos;
        end else if (b[7:3] == 5'b11110) begin
          acc_nxt        = {18'd0, b[2:0]};
          bytes_left_nxt = 2'd3;
          err            = eos;
        end else begin
          err = 1'b1;  // lone continuation or five-plus leading ones
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        acc_nxt        = acc_shift;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 2'd0) begin
          job_valid = 1'b1;
          job       = encode_cp(acc_shift, fmt, eos);
          acc_nxt   = 21'd0;
        end else begin
          err = eos;  // sequence cut short by end of stream
        end
      end
      if (err) begin
        job_valid      = 1'b1;
        job            = err_job(eos);
        bytes_left_nxt = 2'd0;
        acc_nxt        = 21'd0;
        dropping_nxt   = 1'b1;
      end
    end
    if (accept && eos) begin
      bytes_left_nxt = 2'd0;
      acc_nxt        = 21'd0;
      dropping_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      acc_r        <= 21'd0;
      dropping_r   <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

  assign stat.bytes_left = bytes_left_r;
  assign stat.dropping   = dropping_r;

endmodule

// ===== hdl/u2u_fifo.sv =====
// ----------------------------------------------------------------------------
// u2u_fifo
// small job queue decoupling the decoder from the byte serialiser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  u2u_pkg::job_t  wr_job,
  output logic           full,
  input  logic           rd_en,
  output u2u_pkg::job_t  rd_job,
  output logic           rd_valid
);
  import u2u_pkg::*;

  job_t                 slot_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (cnt_r == JOB_CNT_W'(JOB_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== hdl/u2u_back.sv =====
// ----------------------------------------------------------------------------
// u2u_back
// byte serialiser: walks each job's bytes into a registered output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  u2u_pkg::job_t      job,
  output logic               job_done,
  output logic               empty,
  input  logic               pop,
  output u2u_pkg::out_item_t out_item
);
  import u2u_pkg::*;

  byte_idx_t  idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;
  assign load     = job_valid && (!out_valid_r || pop);
  assign at_last  = (idx_r == job.last_idx);
  assign job_done = load && at_last;

  always_comb begin
    case (idx_r)
      IDX_B0:  sel_byte = job.data[7:0];
      IDX_B1:  sel_byte = job.data[15:8];
      IDX_B2:  sel_byte = job.data[23:16];
      IDX_B3:  sel_byte = job.data[31:24];
      default: sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !pop;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.out_byte    = sel_byte;
      out_item_nxt.last_of_run = at_last;
      out_item_nxt.bad_input   = job.bad;
      out_item_nxt.stream_done = at_last && job.eos;
      idx_nxt                  = at_last ? IDX_B0 : byte_idx_t'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_B0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== sim/tb_utf8_to_utf16_utf32_transcoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_utf32_transcoder
// Self-checking bench for the UTF-8 to UTF-16LE/UTF-32LE transcoder. A
// directed list and random streams (well-formed code points, noise bytes and
// broken sequences) feed a bursty byte driver. Each byte taken is decoded by
// a local model into the output bytes it should produce, and a stalling
// monitor checks every output transaction against them in order. The format
// register is switched between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_to_utf16_utf32_transcoder;

  import u2u_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 8;     // pipeline tail before a register write
  localparam int          TAIL_CYCLES   = 24;    // catch stray output after the last byte
  localparam int          STALL_LIMIT   = 3000;  // cycles without any transaction
  localparam int          MAX_REPORTS   = 10;
  localparam logic [15:0] HIGH_SURR_ADD = 16'hD7C0;
  localparam logic [15:0] LOW_SURR_ADD  = 16'hDC00;

  // dut input ports, all driven to known values from time zero
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      push      = 1'b0;
  logic      full;
  in_item_t  in_item   = '0;
  logic      empty;
  logic      pop       = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // bytes still to be sent, and output bytes the decoder model has produced
  in_item_t  utf8_bytes_q[$];
  out_item_t predicted_bytes_q[$];

  // decoder model state
  out_fmt_t    fmt_shadow  = FMT_UTF16;
  logic [1:0]  seq_left    = 2'd0;
  logic [20:0] cp_build    = 21'd0;
  logic        skip_to_eos = 1'b0;

  // driver burst control
  int burst_left = 0;
  int gap_left   = 0;

  // monitor stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age   = 0;
  out_item_t   head_exp;

  int err_count  = 0;
  int idle_count = 0;

  utf8_to_utf16_utf32_transcoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------

  function automatic int lead_ones(input logic [7:0] b);
    casez (b)
      8'b0???????: return 0;
      8'b10??????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 5;
    endcase
  endfunction

  task automatic add_out_byte(input logic [7:0] b, input logic last, input logic bad,
                              input logic done);
    out_item_t r;
    r.out_byte    = b;
    r.last_of_run = last;
    r.bad_input   = bad;
    r.stream_done = done;
    predicted_bytes_q.push_back(r);
  endtask

  task automatic clear_decoder();
    seq_left    = 2'd0;
    cp_build    = 21'd0;
    skip_to_eos = 1'b0;
  endtask

  // one error transaction; without an end mark the rest of the stream is skipped
  task automatic flag_error(input logic eos);
    add_out_byte(8'h00, 1'b1, 1'b1, eos);
    if (eos) begin
      clear_decoder();
    end else begin
      seq_left    = 2'd0;
      cp_build    = 21'd0;
      skip_to_eos = 1'b1;
    end
  endtask

  task automatic transcode_byte(input in_item_t it);
    logic [7:0]  b;
    logic        eos;
    logic        cp_ready;
    logic [15:0] hi;
    logic [15:0] lo;
    int          ones;
    b        = it.in_byte;
    eos      = it.end_of_stream;
    cp_ready = 1'b0;
    if (skip_to_eos) begin
      // dropped silently, the end mark only clears the state
      if (eos) clear_decoder();
    end else if (seq_left == 2'd0) begin
      ones = lead_ones(b);
      if (ones == 0) begin
        cp_build = {13'd0, b};
        cp_ready = 1'b1;
      end else if (ones >= 2 && ones <= 4) begin
        case (ones)
          2:       cp_build = {16'd0, b[4:0]};
          3:       cp_build = {17'd0, b[3:0]};
          default: cp_build = {18'd0, b[2:0]};
        endcase
        seq_left = 2'(ones - 1);
        // a lead byte carrying the end mark is a truncated sequence
        if (eos) flag_error(1'b1);
      end else begin
        flag_error(eos);
      end
    end else if (b[7:6] != 2'b10) begin
      flag_error(eos);
    end else begin
      cp_build = {cp_build[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) cp_ready = 1'b1;
      else if (eos) flag_error(1'b1);
    end

    if (cp_ready) begin
      if (fmt_shadow == FMT_UTF32) begin
        add_out_byte(cp_build[7:0], 1'b0, 1'b0, 1'b0);
        add_out_byte(cp_build[15:8], 1'b0, 1'b0, 1'b0);
        add_out_byte({3'd0, cp_build[20:16]}, 1'b0, 1'b0, 1'b0);
        add_out_byte(8'h00, 1'b1, 1'b0, eos);
      end else if (cp_build[20:16] == 5'd0) begin
        add_out_byte(cp_build[7:0], 1'b0, 1'b0, 1'b0);
        add_out_byte(cp_build[15:8], 1'b1, 1'b0, eos);
      end else begin
        // surrogate pair, each unit kept to 16 bits
        hi = {5'd0, cp_build[20:10]} + HIGH_SURR_ADD;
        lo = {6'd0, cp_build[9:0]} + LOW_SURR_ADD;
        add_out_byte(hi[7:0], 1'b0, 1'b0, 1'b0);
        add_out_byte(hi[15:8], 1'b0, 1'b0, 1'b0);
        add_out_byte(lo[7:0], 1'b0, 1'b0, 1'b0);
        add_out_byte(lo[15:8], 1'b1, 1'b0, eos);
      end
      cp_build = 21'd0;
      if (eos) clear_decoder();
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------

  task automatic queue_byte(input logic [7:0] b, input logic eos);
    in_item_t it;
    it.in_byte       = b;
    it.end_of_stream = eos;
    utf8_bytes_q.push_back(it);
  endtask

  // utf-8 form of a code point in len bytes, longer than needed gives an overlong form
  task automatic queue_code_point(input logic [20:0] cp, input int len, input logic eos);
    logic [7:0]  lead;
    logic [20:0] sh;
    int          k;
    case (len)
      1:       lead = {1'b0, cp[6:0]};
      2:       lead = {3'b110, cp[10:6]};
      3:       lead = {4'b1110, cp[15:12]};
      default: lead = {5'b11110, cp[20:18]};
    endcase
    queue_byte(lead, (len == 1) ? eos : 1'b0);
    for (k = len - 2; k >= 0; k--) begin
      sh = cp >> (6 * k);
      queue_byte({2'b10, sh[5:0]}, (k == 0) ? eos : 1'b0);
    end
  endtask

  // mostly well-formed code points, some noise and broken sequences
  task automatic queue_random_stream(input int n_items);
    int          taken;
    int          kind;
    int          len;
    int          conts;
    int          k;
    logic [20:0] cp;
    logic [7:0]  junk;
    logic        eos;
    logic        trunc;
    taken = 0;
    while (taken < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       cp = 21'($urandom_range(0, 21'h00007F));
          2:       cp = 21'($urandom_range(0, 21'h0007FF));
          3:       cp = 21'($urandom_range(0, 21'h00FFFF));
          default: cp = 21'($urandom_range(0, 21'h1FFFFF));
        endcase
        eos = ($urandom_range(0, 5) == 0);
        queue_code_point(cp, len, eos);
        taken += len;
      end else if (kind == 7) begin
        // noise byte always ends the stream so it never starts a skip
        junk = 8'($urandom);
        queue_byte(junk, 1'b1);
        taken++;
      end else begin
        len   = $urandom_range(2, 4);
        cp    = 21'($urandom);
        conts = $urandom_range(0, len - 2);
        trunc = 1'($urandom_range(0, 1));
        case (len)
          2:       junk = {3'b110, cp[4:0]};
          3:       junk = {4'b1110, cp[3:0]};
          default: junk = {5'b11110, cp[2:0]};
        endcase
        queue_byte(junk, trunc && conts == 0);
        for (k = 1; k <= conts; k++) begin
          junk = 8'($urandom);
          queue_byte({2'b10, junk[5:0]}, trunc && k == conts);
        end
        taken += 1 + conts;
        if (!trunc) begin
          // byte that is not a continuation while the sequence is open
          junk = 8'($urandom);
          if (junk[7:6] == 2'b10) junk[6] = 1'b1;
          eos = 1'($urandom_range(0, 1));
          queue_byte(junk, eos);
          taken++;
          if (!eos) begin
            // skipped bytes up to and including the end mark
            k = $urandom_range(0, 2);
            repeat (k) begin
              junk = 8'($urandom);
              queue_byte(junk, 1'b0);
            end
            junk = 8'($urandom);
            queue_byte(junk, 1'b1);
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequencing helpers, called on a rising edge
  // --------------------------------------------------------------------------

  // hold off until every byte is sent and every output byte is back
  task automatic wait_drained();
    while (utf8_bytes_q.size() != 0 || push || predicted_bytes_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input out_fmt_t f);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    fmt_shadow = f;
  endtask

  task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display({"mismatch (%0s): expected byte %02h last %b bad %b done %b, ",
                "got byte %02h last %b bad %b done %b"},
               what, want.out_byte, want.last_of_run, want.bad_input, want.stream_done,
               got.out_byte, got.last_of_run, got.bad_input, got.stream_done);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of bytes with random gaps, model updated on each transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) transcode_byte(in_item);
      // a byte stays on the port until it is taken
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (utf8_bytes_q.size() != 0) begin
          push    <= 1'b1;
          in_item <= utf8_bytes_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a quarter of the bursts run straight into the next one
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each output transaction, pop follows a rotating pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (predicted_bytes_q.size() == 0) begin
          note_mismatch("nothing expected", '0, out_item);
        end else begin
          head_exp = predicted_bytes_q.pop_front();
          if (out_item.out_byte !== head_exp.out_byte ||
              out_item.last_of_run !== head_exp.last_of_run ||
              out_item.bad_input !== head_exp.bad_input ||
              out_item.stream_done !== head_exp.stream_done)
            note_mismatch("field", head_exp, out_item);
        end
      end
      if (pat_age == 0) begin
        // new pattern now and then, sometimes no stalls at all
        if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
        else stall_pat = 16'($urandom) | 16'h0001;
        pat_age = $urandom_range(16, 80);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_age--;
      end
      pop <= stall_pat[0];
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction means the block has hung
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_count = 0;
      else idle_count++;
      if (idle_count >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, utf-16 output
    write_format(FMT_UTF16);
    queue_byte(8'h00, 1'b0);                     // ascii extremes
    queue_byte(8'h7F, 1'b0);
    queue_code_point(21'h000000, 2, 1'b0);       // overlong zero
    queue_code_point(21'h0007FF, 2, 1'b0);       // largest two-byte value
    queue_code_point(21'h00FFFF, 3, 1'b0);       // largest single utf-16 unit
    queue_code_point(21'h010000, 4, 1'b0);       // smallest surrogate pair
    queue_code_point(21'h1FFFFF, 4, 1'b1);       // largest accumulator, with end mark
    queue_byte(8'h80, 1'b0);                     // lead with a single leading one
    queue_byte(8'h41, 1'b0);                     // skipped
    queue_byte(8'h42, 1'b1);                     // skipped end mark clears the state
    queue_byte(8'hF8, 1'b1);                     // five leading ones, error ends the stream
    queue_byte(8'hC3, 1'b0);                     // bad continuation byte
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hE2, 1'b0);                     // truncated in the middle
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hF0, 1'b1);                     // truncated right at the lead
    wait_drained();

    write_format(FMT_UTF32);
    queue_random_stream(30);
    // sender holds off mid-phase until all output has come back
    wait_drained();
    queue_random_stream(25);
    wait_drained();

    write_format(FMT_UTF16);
    queue_random_stream(30);
    wait_drained();

    write_format(FMT_UTF32);
    queue_random_stream(25);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
